// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GNMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GNMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gnms_pkg.sv =====
// Types and constants for the gradient non-maximum suppression block.
package gnms_pkg;

  // Configuration register map and field widths.
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 13;
  localparam int FW_BITS       = 11;
  localparam int FH_BITS       = 13;
  localparam int ROW_BITS      = 13;
  localparam int HLAST_BITS    = 12;
  localparam int MAX_HEIGHT    = 4096;
  localparam int DIR_BITS      = 15;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'd1;

  localparam logic [FW_BITS-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Request type codes.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Rows of a window column.
  localparam int ROW_TOP = 0;
  localparam int ROW_MID = 1;
  localparam int ROW_BOT = 2;

  // Direction sectors.
  typedef enum logic [1:0] {
    SEC_HORIZ   = 2'd0,
    SEC_DIAG45  = 2'd1,
    SEC_VERT    = 2'd2,
    SEC_DIAG135 = 2'd3
  } sector_e;

  // Rational pi used for the degree conversion.
  localparam longint unsigned PI_NUM  = 64'd245850922;
  localparam longint unsigned PI_DEN  = 64'd78256779;
  localparam longint unsigned DEG_DEN = 64'd360 * PI_DEN;

  // Smallest |direction| that rounds to 23, 68, 113, 158 and 203 degrees.
  localparam logic [DIR_BITS-1:0] DIR_T1 =
    15'((64'd45 * 64'd4096 * PI_NUM + DEG_DEN - 64'd1) / DEG_DEN);
  localparam logic [DIR_BITS-1:0] DIR_T2 =
    15'((64'd135 * 64'd4096 * PI_NUM + DEG_DEN - 64'd1) / DEG_DEN);
  localparam logic [DIR_BITS-1:0] DIR_T3 =
    15'((64'd225 * 64'd4096 * PI_NUM + DEG_DEN - 64'd1) / DEG_DEN);
  localparam logic [DIR_BITS-1:0] DIR_T4 =
    15'((64'd315 * 64'd4096 * PI_NUM + DEG_DEN - 64'd1) / DEG_DEN);
  localparam logic [DIR_BITS-1:0] DIR_T5 =
    15'((64'd405 * 64'd4096 * PI_NUM + DEG_DEN - 64'd1) / DEG_DEN);

  // Position flags of one counted word within the frame.
  typedef struct packed {
    logic pixel;      // word still carries a pixel of this frame
    logic top_clamp;  // column sits in row one, top neighbour clamps
    logic emit;       // word releases a result
    logic end_row;    // result is the last pixel of a row
    logic end_frame;  // result is the last pixel of the frame
  } pos_flags_t;

endpackage

// ===== rtl/gnms_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module gnms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port returns the contents before any write at the same edge.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/gnms_sector.sv =====
// Quantises a gradient direction into one of four sectors.
module gnms_sector (
  input  logic signed [gnms_pkg::DIR_BITS-1:0] grad_direction_i,
  output gnms_pkg::sector_e                    sector_o
);

  logic signed [gnms_pkg::DIR_BITS:0] dir_ext;
  logic [gnms_pkg::DIR_BITS:0]        dir_abs;
  logic [gnms_pkg::DIR_BITS-1:0]      dir_mag;
  logic [2:0]                         band;
  logic [1:0]                         pos_sec;

  // Magnitude of the angle; the most negative code gives exactly 16384.
  always_comb begin
    dir_ext = {grad_direction_i[gnms_pkg::DIR_BITS-1], grad_direction_i};
    dir_abs = dir_ext[gnms_pkg::DIR_BITS] ? 16'(-dir_ext) : 16'(dir_ext);
    dir_mag = dir_abs[gnms_pkg::DIR_BITS-1:0];
  end

  // The number of degree boundaries passed picks the sector; every fourth
  // band wraps back to horizontal, as folding into half a turn does.
  always_comb begin
    band = 3'(dir_mag >= gnms_pkg::DIR_T1) + 3'(dir_mag >= gnms_pkg::DIR_T2) +
           3'(dir_mag >= gnms_pkg::DIR_T3) + 3'(dir_mag >= gnms_pkg::DIR_T4) +
           3'(dir_mag >= gnms_pkg::DIR_T5);
    pos_sec = band[1:0];
    // A negative angle mirrors the diagonals.
    sector_o = gnms_pkg::sector_e'(dir_ext[gnms_pkg::DIR_BITS] ?
                                   2'(2'd0 - pos_sec) : pos_sec);
  end

endmodule

// ===== rtl/gnms_raster.sv =====
// Frame size registers and raster position counters.
module gnms_raster #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gnms_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [gnms_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  logic                                advance_i,
  output logic [$clog2(MAX_WIDTH)-1:0]        col_o,
  output gnms_pkg::pos_flags_t                flags_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > gnms_pkg::FW_BITS) ? CW + 1 : gnms_pkg::FW_BITS;

  logic [gnms_pkg::FW_BITS-1:0]    fw_q;
  logic [gnms_pkg::FH_BITS-1:0]    fh_q;
  logic [CW-1:0]                   col_q;
  logic [gnms_pkg::ROW_BITS-1:0]   row_q;
  logic [EW-1:0]                   fw_ext;
  logic [EW-1:0]                   wlast_ext;
  logic [CW-1:0]                   wlast;
  logic [gnms_pkg::HLAST_BITS-1:0] hlast;
  logic [gnms_pkg::ROW_BITS-1:0]   hlast_ext;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= gnms_pkg::FRAME_WIDTH_RST;
      fh_q <= gnms_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gnms_pkg::CFG_FRAME_WIDTH:  fw_q <= cfg_wdata_i[gnms_pkg::FW_BITS-1:0];
        gnms_pkg::CFG_FRAME_HEIGHT: fh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Last column and last row, with zero acting as one and large values capped.
  always_comb begin
    fw_ext = EW'(fw_q);
    if (fw_ext == '0) begin
      wlast_ext = '0;
    end else if (fw_ext > EW'(MAX_WIDTH)) begin
      wlast_ext = EW'(MAX_WIDTH - 1);
    end else begin
      wlast_ext = fw_ext - EW'(1);
    end
    wlast = wlast_ext[CW-1:0];

    if (fh_q == '0) begin
      hlast = '0;
    end else if (fh_q > 13'(gnms_pkg::MAX_HEIGHT)) begin
      hlast = 12'(gnms_pkg::MAX_HEIGHT - 1);
    end else begin
      hlast = 12'(fh_q - 13'd1);
    end
    hlast_ext = {1'b0, hlast};
  end

  // Position flags of the word at the current count. Rows past the last one
  // are the drain row and the single word that closes the frame.
  always_comb begin
    flags_o.pixel     = (row_q <= hlast_ext);
    flags_o.top_clamp = (row_q == 13'd1);
    flags_o.emit      = (row_q >= 13'd2) || ((row_q == 13'd1) && (col_q != '0));
    flags_o.end_row   = (col_q == '0);
    flags_o.end_frame = (row_q == hlast_ext + 13'd2) && (col_q == '0);
  end

  // Raster counters; a configuration write restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance_i) begin
      if (flags_o.end_frame) begin
        col_q <= '0;
        row_q <= '0;
      end else if (col_q == wlast) begin
        col_q <= '0;
        row_q <= row_q + 13'd1;
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  assign col_o = col_q;

endmodule

// ===== rtl/gnms_nms.sv =====
// Window registers and the suppression compare along the gradient sector.
module gnms_nms #(
  parameter int MAG_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  gnms_pkg::pos_flags_t flags_i,
  input  logic [MAG_BITS-1:0]  pix_mag_i,
  input  logic [MAG_BITS-1:0]  mid_i,
  input  logic [MAG_BITS-1:0]  top_raw_i,
  input  gnms_pkg::sector_e    sec_rd_i,
  output logic [MAG_BITS-1:0]  bot_o,
  output logic [MAG_BITS-1:0]  kept_o
);

  logic [2:0][MAG_BITS-1:0] left_q;
  logic [2:0][MAG_BITS-1:0] ctr_q;
  gnms_pkg::sector_e        ctr_sec_q;
  logic                     ctr_col0_q;
  logic [2:0][MAG_BITS-1:0] new_col;
  logic [2:0][MAG_BITS-1:0] left_col;
  logic [2:0][MAG_BITS-1:0] right_col;
  logic [MAG_BITS-1:0]      n1;
  logic [MAG_BITS-1:0]      n2;
  logic [MAG_BITS-1:0]      ctr_mag;

  // New column from the line buffers and the incoming pixel. Rows beyond the
  // frame take the value of the edge row.
  always_comb begin
    new_col[gnms_pkg::ROW_MID] = mid_i;
    new_col[gnms_pkg::ROW_TOP] = flags_i.top_clamp ? mid_i : top_raw_i;
    new_col[gnms_pkg::ROW_BOT] = flags_i.pixel ? pix_mag_i : mid_i;
    bot_o = new_col[gnms_pkg::ROW_BOT];
  end

  // Horizontal edge replication: the centre stands in for a missing side.
  always_comb begin
    left_col  = ctr_col0_q ? ctr_q : left_q;
    right_col = flags_i.end_row ? ctr_q : new_col;
    ctr_mag   = ctr_q[gnms_pkg::ROW_MID];
  end

  // Neighbour pair along the sector of the centre pixel.
  always_comb begin
    case (ctr_sec_q)
      gnms_pkg::SEC_HORIZ: begin
        n1 = left_col[gnms_pkg::ROW_MID];
        n2 = right_col[gnms_pkg::ROW_MID];
      end
      gnms_pkg::SEC_DIAG45: begin
        n1 = left_col[gnms_pkg::ROW_TOP];
        n2 = right_col[gnms_pkg::ROW_BOT];
      end
      gnms_pkg::SEC_VERT: begin
        n1 = ctr_q[gnms_pkg::ROW_BOT];
        n2 = ctr_q[gnms_pkg::ROW_TOP];
      end
      gnms_pkg::SEC_DIAG135: begin
        n1 = right_col[gnms_pkg::ROW_TOP];
        n2 = left_col[gnms_pkg::ROW_BOT];
      end
      default: begin
        n1 = left_col[gnms_pkg::ROW_MID];
        n2 = right_col[gnms_pkg::ROW_MID];
      end
    endcase
    kept_o = ((ctr_mag >= n1) && (ctr_mag >= n2)) ? ctr_mag : '0;
  end

  // Window shifts one column for every counted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q     <= '0;
      ctr_q      <= '0;
      ctr_sec_q  <= gnms_pkg::SEC_HORIZ;
      ctr_col0_q <= 1'b0;
    end else if (fire_i) begin
      left_q     <= ctr_q;
      ctr_q      <= new_col;
      ctr_sec_q  <= sec_rd_i;
      ctr_col0_q <= flags_i.end_row;
    end
  end

endmodule

// ===== rtl/gradient_non_maximum_suppression_top.sv =====
// Top level of the streaming gradient non-maximum suppression block.
//
// Channel  Dir  Handshake                 Word
// in       in   in_valid_i / in_stall_o   req_type, grad_magnitude, grad_direction
// out      out  out_valid_o / out_stall_i kept_magnitude, end_of_row, end_of_frame
// cfg      in   cfg_we_i, no wait         cfg_idx_i, cfg_wdata_i
//
// One word is taken per clock while in_stall_o is low. A result passes from
// the registered line buffer read and compare stage input register through
// the window compare into the output register. The word counted k-th in a
// frame releases pixel k-W-1, so a frame is W*H pixels followed by W+1 drain words.
// Reset clears the counters and window and loads 640 by 480; the line buffers
// are not cleared, as every entry is written in a frame before it is read.
// in_stall_o rises only while a result waits in a stalled output register.
module gradient_non_maximum_suppression_top #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAG_BITS  = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [gnms_pkg::CFG_IDX_BITS-1:0]         cfg_idx_i,
  input  logic [gnms_pkg::CFG_DATA_BITS-1:0]        cfg_wdata_i,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic                                      req_type_i,
  input  logic [MAG_BITS-1:0]                       grad_magnitude_i,
  input  logic signed [gnms_pkg::DIR_BITS-1:0]      grad_direction_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic [MAG_BITS-1:0]                       kept_magnitude_o,
  output logic                                      end_of_row_o,
  output logic                                      end_of_frame_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  gnms_pkg::pos_flags_t flags;
  logic [CW-1:0]        col_now;
  gnms_pkg::sector_e    in_sector;
  logic                 counted;
  logic                 in_accept;
  logic                 advance;
  logic                 out_free;
  logic                 s1_fire;

  logic                 s1_valid_q;
  gnms_pkg::pos_flags_t s1_flags_q;
  logic [MAG_BITS-1:0]  s1_mag_q;
  gnms_pkg::sector_e    s1_sec_q;
  logic [CW-1:0]        s1_col_q;

  logic                 byp_d;
  logic                 byp_q;
  logic [MAG_BITS-1:0]  byp_a_q;
  logic [MAG_BITS-1:0]  byp_b_q;
  gnms_pkg::sector_e    byp_s_q;

  logic [MAG_BITS-1:0]  ram_a_rd;
  logic [MAG_BITS-1:0]  ram_b_rd;
  logic [1:0]           ram_s_rd;
  logic [MAG_BITS-1:0]  mid;
  logic [MAG_BITS-1:0]  top_raw;
  gnms_pkg::sector_e    sec_rd;
  logic [MAG_BITS-1:0]  col_bot;
  logic [MAG_BITS-1:0]  kept;

  logic                 out_valid_q;
  logic [MAG_BITS-1:0]  out_kept_q;
  logic                 out_eor_q;
  logic                 out_eof_q;

  // Frame size and raster position.
  gnms_raster #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .col_o       (col_now),
    .flags_o     (flags)
  );

  // Sector of the incoming direction.
  gnms_sector u_sector (
    .grad_direction_i (grad_direction_i),
    .sector_o         (in_sector)
  );

  // Handshake. A flush before the last pixel of the frame is taken and dropped.
  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    s1_fire    = s1_valid_q && (!s1_flags_q.emit || out_free);
    in_stall_o = s1_valid_q && !s1_fire;
    in_accept  = in_valid_i && !in_stall_o;
    counted    = !(flags.pixel && (req_type_i == gnms_pkg::REQ_FLUSH));
    advance    = in_accept && counted;
    // The buffer write of the word in flight lands on the address read now.
    byp_d      = s1_valid_q && (s1_col_q == col_now);
  end

  // Compare stage input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= 1'b1;
      byp_q      <= byp_d;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_flags_q <= flags;
      s1_mag_q   <= grad_magnitude_i;
      s1_sec_q   <= in_sector;
      s1_col_q   <= col_now;
      byp_a_q    <= col_bot;
      byp_b_q    <= mid;
      byp_s_q    <= s1_sec_q;
    end
  end

  // Line buffers: row above the current one, row above that, and sectors.
  gnms_ram #(
    .WIDTH (MAG_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_a (
    .clk_i     (clk_i),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_col_q),
    .wr_data_i (col_bot),
    .rd_en_i   (advance),
    .rd_addr_i (col_now),
    .rd_data_o (ram_a_rd)
  );

  gnms_ram #(
    .WIDTH (MAG_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_b (
    .clk_i     (clk_i),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_col_q),
    .wr_data_i (mid),
    .rd_en_i   (advance),
    .rd_addr_i (col_now),
    .rd_data_o (ram_b_rd)
  );

  gnms_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_sector_line (
    .clk_i     (clk_i),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_col_q),
    .wr_data_i (s1_sec_q),
    .rd_en_i   (advance),
    .rd_addr_i (col_now),
    .rd_data_o (ram_s_rd)
  );

  // Buffer read data, with the forwarded write where the addresses met.
  always_comb begin
    mid     = byp_q ? byp_a_q : ram_a_rd;
    top_raw = byp_q ? byp_b_q : ram_b_rd;
    sec_rd  = byp_q ? byp_s_q : gnms_pkg::sector_e'(ram_s_rd);
  end

  // Window and compare.
  gnms_nms #(
    .MAG_BITS (MAG_BITS)
  ) u_nms (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s1_fire),
    .flags_i   (s1_flags_q),
    .pix_mag_i (s1_mag_q),
    .mid_i     (mid),
    .top_raw_i (top_raw),
    .sec_rd_i  (sec_rd),
    .bot_o     (col_bot),
    .kept_o    (kept)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_flags_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_flags_q.emit) begin
      out_kept_q <= kept;
      out_eor_q  <= s1_flags_q.end_row;
      out_eof_q  <= s1_flags_q.end_frame;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kept_magnitude_o = out_kept_q;
  assign end_of_row_o     = out_eor_q;
  assign end_of_frame_o   = out_eof_q;

endmodule

// ===== rtl/gnms_checker.sv =====
// Port-level checks for the suppression block, bound to its top level.
`include "assert_macros.svh"

module gnms_checker #(
  parameter int MAG_BITS = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [MAG_BITS-1:0] kept_magnitude_o,
  input logic                end_of_row_o,
  input logic                end_of_frame_o
);

  // The last pixel of a frame is always the last pixel of a row.
  `GNMS_ASSERT_IMPL(a_eof_on_eor, clk_i, rst_ni, out_valid_o && end_of_frame_o, end_of_row_o, "end of frame without end of row")

  // The input side stalls only behind a stalled, full output register.
  `GNMS_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without output back-pressure")

  // A stalled result holds its word.
  `GNMS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(kept_magnitude_o) && $stable(end_of_row_o) && $stable(end_of_frame_o), "stalled result changed")

endmodule

bind gradient_non_maximum_suppression_top gnms_checker #(
  .MAG_BITS (MAG_BITS)
) u_gnms_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .kept_magnitude_o (kept_magnitude_o),
  .end_of_row_o     (end_of_row_o),
  .end_of_frame_o   (end_of_frame_o)
);

// ===== tb/gradient_non_maximum_suppression_top_tb.sv =====
// Self-checking testbench for the streaming gradient non-maximum suppression block.
module gradient_non_maximum_suppression_top_tb;
  import gnms_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;
  localparam int MAG_W = 16;
  localparam longint unsigned PI_N = 64'd245850922;
  localparam longint unsigned PI_D = 64'd78256779;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 1400;
  localparam int QUIET_WORDS = 300;

  typedef struct packed {
    logic [MAG_W-1:0] kept;
    logic             eor;
    logic             eof;
  } nms_word_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CFG_IDX_BITS-1:0]    cfg_idx_i;
  logic [CFG_DATA_BITS-1:0]   cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic                       req_type_i;
  logic [MAG_W-1:0]           grad_magnitude_i;
  logic signed [DIR_BITS-1:0] grad_direction_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [MAG_W-1:0]           kept_magnitude_o;
  logic                       end_of_row_o;
  logic                       end_of_frame_o;

  // Shadow of the block: line stores, geometry registers and frame counters.
  logic [MAG_W-1:0] mag_lines [4][MAX_W];
  sector_e          sec_lines [4][MAX_W];
  logic [FW_BITS-1:0] reg_width;
  logic [FH_BITS-1:0] reg_height;
  int col_pos;
  int row_pos;
  int out_pos;
  int fill_pos;
  nms_word_t expected_words[$];

  int  counted_words;
  int  error_count;
  int  quiet_cycles;
  bit  idle_en;

  gradient_non_maximum_suppression_top #(
    .MAX_WIDTH(MAX_W),
    .MAG_BITS (MAG_W)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .grad_magnitude_i(grad_magnitude_i),
    .grad_direction_i(grad_direction_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kept_magnitude_o(kept_magnitude_o),
    .end_of_row_o    (end_of_row_o),
    .end_of_frame_o  (end_of_frame_o)
  );

  // Clock with a period of ten units.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Effective geometry: zero acts as one and oversize values saturate.
  function automatic int active_width();
    int w;
    w = reg_width;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int active_height();
    int h;
    h = reg_height;
    if (h == 0) h = 1;
    if (h > MAX_H) h = MAX_H;
    return h;
  endfunction

  // Rounds the angle to whole degrees, folds it into [0,180) and picks the nearest
  // multiple of 45 degrees, with 22 rounding down and 23 rounding up.
  function automatic sector_e direction_sector(logic signed [DIR_BITS-1:0] dir);
    int dval;
    longint unsigned amag;
    longint unsigned deg;
    int d;
    dval = dir;
    amag = (dval < 0) ? longint'(-dval) : longint'(dval);
    deg = (64'd360 * amag * PI_D + 64'd4096 * PI_N) / (64'd8192 * PI_N);
    d = int'(deg);
    if (dval < 0) d = -d;
    d = (d + 360) % 180;
    return sector_e'(((d + 22) / 45) % 4);
  endfunction

  // Smallest absolute direction that rounds to 23 + 45*k degrees.
  function automatic int sector_edge(int k);
    longint unsigned num;
    longint unsigned den;
    num = longint'(2 * (23 + 45 * k) - 1) * 64'd4096 * PI_N;
    den = 64'd360 * PI_D;
    return int'((num + den - 1) / den);
  endfunction

  // Magnitude at a window position, with out-of-frame positions taking the edge pixel.
  function automatic logic [MAG_W-1:0] line_mag(int x, int y, int w, int h);
    if (x < 0) x = 0;
    if (x > w - 1) x = w - 1;
    if (y < 0) y = 0;
    if (y > h - 1) y = h - 1;
    return mag_lines[y % 4][x];
  endfunction

  function automatic void restart_frame();
    col_pos  = 0;
    row_pos  = 0;
    out_pos  = 0;
    fill_pos = 0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_BITS-1:0] idx,
                                         logic [CFG_DATA_BITS-1:0] value);
    if (idx == CFG_FRAME_WIDTH) reg_width = value[FW_BITS-1:0];
    else reg_height = value[FH_BITS-1:0];
    restart_frame();
  endfunction

  // Stores one accepted word and queues the suppressed pixel that it releases.
  function automatic void predict_word(logic kind, logic [MAG_W-1:0] mag,
                                       logic signed [DIR_BITS-1:0] dir);
    int w;
    int h;
    int x;
    int y;
    logic [MAG_W-1:0] centre;
    logic [MAG_W-1:0] n1;
    logic [MAG_W-1:0] n2;
    nms_word_t res;
    w = active_width();
    h = active_height();
    if (row_pos < h) begin
      // A flush is ignored while pixels of the frame are still due.
      if (kind == REQ_FLUSH) return;
      mag_lines[row_pos % 4][col_pos] = mag;
      sec_lines[row_pos % 4][col_pos] = direction_sector(dir);
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end
    counted_words++;
    if (fill_pos < w + 1) begin
      fill_pos++;
      return;
    end
    x = out_pos % w;
    y = out_pos / w;
    centre = mag_lines[y % 4][x];
    case (sec_lines[y % 4][x])
      SEC_HORIZ: begin
        n1 = line_mag(x - 1, y, w, h);
        n2 = line_mag(x + 1, y, w, h);
      end
      SEC_DIAG45: begin
        n1 = line_mag(x - 1, y - 1, w, h);
        n2 = line_mag(x + 1, y + 1, w, h);
      end
      SEC_VERT: begin
        n1 = line_mag(x, y + 1, w, h);
        n2 = line_mag(x, y - 1, w, h);
      end
      default: begin
        n1 = line_mag(x + 1, y - 1, w, h);
        n2 = line_mag(x - 1, y + 1, w, h);
      end
    endcase
    res.kept = (centre >= n1 && centre >= n2) ? centre : '0;
    res.eor  = (x == w - 1);
    res.eof  = (out_pos == w * h - 1);
    expected_words.push_back(res);
    out_pos++;
    if (out_pos >= w * h) restart_frame();
  endfunction

  // Random magnitudes lean towards small values so that ties are frequent.
  function automatic logic [MAG_W-1:0] random_mag();
    case ($urandom_range(3))
      0: return MAG_W'($urandom_range(3));
      1: return $urandom_range(1) ? '1 : '0;
      default: return MAG_W'($urandom());
    endcase
  endfunction

  // Directions near the sector edges, within +-pi, or over the whole field.
  function automatic logic signed [DIR_BITS-1:0] random_dir();
    int a;
    case ($urandom_range(3))
      0: begin
        a = sector_edge($urandom_range(4)) + int'($urandom_range(2)) - 1;
        return DIR_BITS'($urandom_range(1) ? -a : a);
      end
      1: return DIR_BITS'(int'($urandom_range(25736)) - 12868);
      default: return DIR_BITS'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // Offers one word, idling at random first, and holds it until it is taken.
  task automatic send_word(input logic kind, input logic [MAG_W-1:0] mag,
                           input logic signed [DIR_BITS-1:0] dir);
    @(negedge clk_i);
    while (idle_en && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= kind;
    grad_magnitude_i <= mag;
    grad_direction_i <= dir;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(kind, mag, dir);
  endtask

  task automatic send_pixel(input logic [MAG_W-1:0] mag,
                            input logic signed [DIR_BITS-1:0] dir);
    send_word(REQ_PIXEL, mag, dir);
  endtask

  // A flush carries random payload bits that the block must ignore.
  task automatic send_flush();
    send_word(REQ_FLUSH, random_mag(), random_dir());
  endtask

  // Releases the input and waits until every queued result is back.
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes both geometry registers once the block has gone quiet.
  task automatic set_geometry(input int w_val, input int h_val);
    logic [CFG_DATA_BITS-1:0] wv;
    logic [CFG_DATA_BITS-1:0] hv;
    wv = CFG_DATA_BITS'(w_val);
    hv = CFG_DATA_BITS'(h_val);
    wait_results_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_FRAME_WIDTH;
    cfg_wdata_i <= wv;
    @(posedge clk_i);
    apply_register(CFG_FRAME_WIDTH, wv);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_FRAME_HEIGHT;
    cfg_wdata_i <= hv;
    @(posedge clk_i);
    apply_register(CFG_FRAME_HEIGHT, hv);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random pixels, optionally salted with ignored flushes, then drain words.
  task automatic stream_frame(input int pixels, input int drains, input bit noise);
    int i;
    for (i = 0; i < pixels; i++) begin
      if (noise && $urandom_range(99) < 8) send_flush();
      send_pixel(random_mag(), random_dir());
    end
    for (i = 0; i < drains; i++) begin
      if ($urandom_range(3) == 0) send_pixel(random_mag(), random_dir());
      else send_flush();
    end
  endtask

  // The reset geometry of 640 by 480 releases its first pixels after 641 words.
  task automatic test_reset_size();
    stream_frame(645, 0, 0);
  endtask

  // A 4 by 4 frame with extreme magnitudes, ties and directions either side of
  // every sector edge, including angles beyond pi.
  task automatic test_directed_frame();
    int mags[16];
    int dirs[16];
    int e[5];
    int i;
    for (i = 0; i < 5; i++) e[i] = sector_edge(i);
    mags = '{65535, 0, 500, 500,
             700, 65535, 700, 1,
             1, 700, 700, 65535,
             0, 300, 65535, 300};
    dirs = '{0, e[0] - 1, e[0], -e[0],
             -(e[0] - 1), e[1] - 1, -e[1], e[2] - 1,
             e[2], -e[3], e[3] - 1, e[4],
             -(e[4] - 1), 12868, -12868, 16383};
    set_geometry(4, 4);
    // A flush ahead of any pixel is ignored.
    send_flush();
    for (i = 0; i < 16; i++) begin
      send_pixel(MAG_W'(mags[i]), DIR_BITS'(dirs[i]));
      // So is one in the middle of the frame.
      if (i == 7) send_flush();
    end
    // Drain: pixels past the end of the frame act as flushes.
    send_flush();
    send_pixel(16'hFFFF, 15'sd0);
    send_flush();
    send_flush();
    send_pixel(16'h1234, DIR_BITS'(e[1]));
  endtask

  // Degenerate and saturated geometries.
  task automatic test_geometry_extremes();
    set_geometry(0, 0);
    send_pixel(16'hFFFF, DIR_BITS'(-16384));
    send_flush();
    send_pixel(16'h0000, 15'sd16383);
    stream_frame(1, 2, 0);
    set_geometry(1, 1);
    stream_frame(1, 2, 0);
    set_geometry(2047, 1);
    stream_frame(MAX_W, MAX_W + 1, 0);
    set_geometry(1, 8191);
    stream_frame(MAX_H, 2, 0);
    // Widest frame left unfinished; the next write restarts it.
    set_geometry(MAX_W, MAX_H);
    stream_frame(MAX_W + 16, 0, 0);
  endtask

  // Mostly complete small frames with random content, some abandoned part way,
  // and one hold-off mid-frame until all results are back.
  task automatic test_random_frames();
    int start;
    int w;
    int h;
    int we;
    int he;
    int split;
    bit paused;
    start  = counted_words;
    paused = 1'b0;
    while (counted_words - start < RANDOM_WORDS) begin
      case ($urandom_range(9))
        0: w = 0;
        1: w = $urandom_range(13, 40);
        default: w = $urandom_range(1, 8);
      endcase
      h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
      set_geometry(w, h);
      we = (w == 0) ? 1 : w;
      he = (h == 0) ? 1 : h;
      repeat ($urandom_range(1, 3)) begin
        idle_en = (counted_words - start) >= QUIET_WORDS;
        split = $urandom_range(0, we * he);
        if (!paused && counted_words - start >= RANDOM_WORDS / 2) begin
          stream_frame(split, 0, 1);
          wait_results_drained();
          paused = 1'b1;
          stream_frame(we * he - split, we + 1, 1);
        end else if ($urandom_range(9) == 0) begin
          stream_frame(split, $urandom_range(0, we), 1);
          break;
        end else begin
          stream_frame(we * he, we + 1, 1);
        end
      end
    end
    idle_en = 1'b1;
  endtask

  // Result side: random stall, driven at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= idle_en && ($urandom_range(99) < 17);
  end

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk_i) begin
    nms_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result with nothing expected", kept_magnitude_o, '0);
      end else begin
        want = expected_words.pop_front();
        if (kept_magnitude_o !== want.kept)
          report_mismatch("kept_magnitude", kept_magnitude_o, want.kept);
        if (end_of_row_o !== want.eor)
          report_mismatch("end_of_row", end_of_row_o, want.eor);
        if (end_of_frame_o !== want.eof)
          report_mismatch("end_of_frame", end_of_frame_o, want.eof);
      end
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sequence of tests.
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_FRAME_WIDTH;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    req_type_i       = REQ_PIXEL;
    grad_magnitude_i = '0;
    grad_direction_i = '0;
    out_stall_i      = 1'b0;
    reg_width        = FW_BITS'(640);
    reg_height       = FH_BITS'(480);
    restart_frame();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni  <= 1'b1;
    idle_en = 1'b1;
    test_reset_size();
    test_directed_frame();
    test_geometry_extremes();
    test_random_frames();
    wait_results_drained();
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
